### hdl/swd_pkg.sv
package swd_pkg;

    // Field and register widths fixed by the interface
    localparam int CMD_W      = 2;
    localparam int STATUS_W   = 2;
    localparam int ANGLE_W    = 15;
    localparam int MIN_DIST_W = 12;
    localparam int WINDOW_W   = 16;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 1;

    // Angle arithmetic: z in 2^-16 degree, signed
    localparam int Z_W          = 27;
    localparam int ATAN_W       = 22;
    localparam int ATAN_IDX_W   = 5;
    localparam int SCALE_SHIFT  = 24;
    localparam int ROUND_SHIFT  = 10;

    localparam logic signed [Z_W-1:0] DEG180_UNITS = Z_W'(180 * 65536);
    localparam logic signed [Z_W-1:0] DEG360_UNITS = Z_W'(360 * 65536);
    localparam logic [Z_W-1:0]        ROUND_HALF   = Z_W'(512);
    localparam logic [Z_W-ROUND_SHIFT-2:0] ANGLE_FULL = (Z_W-ROUND_SHIFT-1)'(23040);

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK    = 2'd0,
        CMD_PRESS   = 2'd1,
        CMD_RELEASE = 2'd2
    } cmd_t;

    localparam logic [STATUS_W-1:0] STAT_IGNORE = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_MAYBE  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_CANCEL = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_FINISH = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_DISTANCE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_TICKS = 1'b1;

    typedef struct packed {
        logic busy;
        logic done;
    } cordic_stat_t;

    // atan(2^-i) in 2^-16 degree, rounded to nearest
    function automatic logic [ATAN_W-1:0] atan_entry(input logic [ATAN_IDX_W-1:0] idx);
        logic [ATAN_W-1:0] v;
        case (idx)
            5'd0:    v = 22'd2949120;
            5'd1:    v = 22'd1740967;
            5'd2:    v = 22'd919879;
            5'd3:    v = 22'd466945;
            5'd4:    v = 22'd234379;
            5'd5:    v = 22'd117304;
            5'd6:    v = 22'd58666;
            5'd7:    v = 22'd29335;
            5'd8:    v = 22'd14668;
            5'd9:    v = 22'd7334;
            5'd10:   v = 22'd3667;
            5'd11:   v = 22'd1833;
            5'd12:   v = 22'd917;
            5'd13:   v = 22'd458;
            5'd14:   v = 22'd229;
            5'd15:   v = 22'd115;
            5'd16:   v = 22'd57;
            5'd17:   v = 22'd29;
            5'd18:   v = 22'd14;
            5'd19:   v = 22'd7;
            5'd20:   v = 22'd4;
            5'd21:   v = 22'd2;
            5'd22:   v = 22'd1;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

endpackage

### hdl/swd_cordic.sv
module swd_cordic #(
    parameter int COORD_BITS       = 12,
    parameter int ANGLE_ITERATIONS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic signed [COORD_BITS:0]      dx,
    input  logic signed [COORD_BITS:0]      dy,
    output swd_pkg::cordic_stat_t           stat,
    output logic [swd_pkg::ANGLE_W-1:0]     angle
);

    localparam int W  = COORD_BITS + swd_pkg::SCALE_SHIFT + 3;
    localparam int IW = $clog2(ANGLE_ITERATIONS);
    localparam int ZW = swd_pkg::Z_W;
    localparam int QW = ZW - swd_pkg::ROUND_SHIFT - 1;
    localparam logic [IW-1:0] LAST_ITER = IW'(ANGLE_ITERATIONS - 1);

    typedef enum logic [3:0] {
        C_IDLE  = 4'b0001,
        C_ROT   = 4'b0010,
        C_WRAP  = 4'b0100,
        C_ROUND = 4'b1000
    } cstate_t;

    cstate_t                    state_reg, state_next;
    logic [IW-1:0]              iter_reg, iter_next;
    logic signed [W-1:0]        x_reg, x_next;
    logic signed [W-1:0]        y_reg, y_next;
    logic signed [ZW-1:0]       z_reg, z_next;
    logic                       zero_reg, zero_next;
    logic                       done_reg, done_next;
    logic [swd_pkg::ANGLE_W-1:0] angle_reg, angle_next;

    logic signed [W-1:0]  dx_s, dy_s, x_sh, y_sh;
    logic signed [ZW-1:0] atan_z;
    logic                 rot_up;
    logic [ZW-1:0]        z_rnd;
    logic [QW-1:0]        q;

    assign dx_s   = W'(dx) <<< swd_pkg::SCALE_SHIFT;
    assign dy_s   = W'(dy) <<< swd_pkg::SCALE_SHIFT;
    assign x_sh   = x_reg >>> iter_reg;
    assign y_sh   = y_reg >>> iter_reg;
    assign atan_z = $signed(ZW'(swd_pkg::atan_entry(swd_pkg::ATAN_IDX_W'(iter_reg))));
    assign rot_up = !y_reg[W-1] && (y_reg != '0);
    assign z_rnd  = $unsigned(z_reg) + swd_pkg::ROUND_HALF;
    assign q      = z_rnd[ZW-2:swd_pkg::ROUND_SHIFT];

    always_comb
    begin
        state_next = state_reg;
        iter_next  = iter_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        z_next     = z_reg;
        zero_next  = zero_reg;
        done_next  = 1'b0;
        angle_next = angle_reg;
        unique case (state_reg)
            C_IDLE:
            begin
                if (start)
                begin
                    // fold the left half-plane over by 180 degrees
                    zero_next  = (dx == '0) && (dy == '0);
                    iter_next  = '0;
                    if (dx[COORD_BITS])
                    begin
                        x_next = -dx_s;
                        y_next = dy_s;
                        z_next = swd_pkg::DEG180_UNITS;
                    end
                    else
                    begin
                        x_next = dx_s;
                        y_next = -dy_s;
                        z_next = '0;
                    end
                    state_next = C_ROT;
                end
            end
            C_ROT:
            begin
                if (rot_up)
                begin
                    x_next = x_reg + y_sh;
                    y_next = y_reg - x_sh;
                    z_next = z_reg + atan_z;
                end
                else
                begin
                    x_next = x_reg - y_sh;
                    y_next = y_reg + x_sh;
                    z_next = z_reg - atan_z;
                end
                iter_next = iter_reg + 1'b1;
                if (iter_reg == LAST_ITER)
                begin
                    state_next = C_WRAP;
                end
            end
            C_WRAP:
            begin
                if (z_reg[ZW-1])
                begin
                    z_next = z_reg + swd_pkg::DEG360_UNITS;
                end
                state_next = C_ROUND;
            end
            C_ROUND:
            begin
                if (zero_reg)
                begin
                    angle_next = '0;
                end
                else if (q >= swd_pkg::ANGLE_FULL)
                begin
                    angle_next = swd_pkg::ANGLE_W'(q - swd_pkg::ANGLE_FULL);
                end
                else
                begin
                    angle_next = swd_pkg::ANGLE_W'(q);
                end
                done_next  = 1'b1;
                state_next = C_IDLE;
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        iter_reg  <= iter_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        z_reg     <= z_next;
        zero_reg  <= zero_next;
        angle_reg <= angle_next;
    end

    assign stat.busy = (state_reg != C_IDLE);
    assign stat.done = done_reg;
    assign angle     = angle_reg;

endmodule

### hdl/swipe_direction_detector_core.sv
// Swipe direction detector. Each input item is a touch event: tick, press or
// release with a pointer position. Ticks and presses are answered in the cycle
// after acceptance (ignore and maybe-gesture); a release that is too short or
// comes after the window has run out is answered with cancel in the same way.
// A release that finishes a swipe runs a vectoring CORDIC on the shift-and-add
// unit in swd_cordic, one iteration per cycle, through its rotation, wrap and
// rounding steps before the result is loaded. The block takes one item at a
// time: s_tready stays low while the angle is being worked out, and otherwise
// rises as soon as the result slot is empty or being taken. The angle is
// counterclockwise from +x with y growing downwards on screen, in 1/64 degree.
// Configuration writes are expected only while the block is idle.
module swipe_direction_detector_core #(
    parameter int COORD_BITS       = 12,
    parameter int ANGLE_ITERATIONS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // cfg
    input  logic                                cfg_we,
    input  logic [swd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [swd_pkg::CFG_W-1:0]           cfg_wdata,
    // input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [((2*COORD_BITS+9)/8)*8-1:0]   s_tdata,  // command, pos_x, pos_y
    // result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [23:0]                         m_tdata   // status, angle
);

    localparam int MD_W = (COORD_BITS > swd_pkg::MIN_DIST_W) ? COORD_BITS
                                                              : swd_pkg::MIN_DIST_W;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_CALC = 2'b10
    } state_t;

    state_t                             state_reg, state_next;
    logic [swd_pkg::MIN_DIST_W-1:0]     min_dist_reg;
    logic [swd_pkg::WINDOW_W-1:0]       win_ticks_reg;
    logic [COORD_BITS-1:0]              start_x_reg, start_x_next;
    logic [COORD_BITS-1:0]              start_y_reg, start_y_next;
    logic [swd_pkg::WINDOW_W-1:0]       win_left_reg, win_left_next;
    logic                               out_valid_reg, out_valid_next;
    logic [swd_pkg::STATUS_W-1:0]       status_reg, status_next;
    logic [swd_pkg::ANGLE_W-1:0]        angle_reg, angle_next;

    swd_pkg::cmd_t                      cmd;
    logic [COORD_BITS-1:0]              pos_x, pos_y;
    logic                               accept;
    logic signed [COORD_BITS:0]         dx, dy;
    logic [COORD_BITS-1:0]              ax, ay;
    logic                               too_short;
    logic                               cordic_start;
    swd_pkg::cordic_stat_t              cstat;
    logic [swd_pkg::ANGLE_W-1:0]        cordic_angle;

    // unpack the input item
    assign cmd   = swd_pkg::cmd_t'(s_tdata[swd_pkg::CMD_W-1:0]);
    assign pos_x = s_tdata[swd_pkg::CMD_W +: COORD_BITS];
    assign pos_y = s_tdata[swd_pkg::CMD_W+COORD_BITS +: COORD_BITS];

    assign s_tready = (state_reg == ST_IDLE) && (!out_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;

    // displacement from the press point, per-axis magnitude
    assign dx = $signed({1'b0, pos_x}) - $signed({1'b0, start_x_reg});
    assign dy = $signed({1'b0, pos_y}) - $signed({1'b0, start_y_reg});
    assign ax = dx[COORD_BITS] ? COORD_BITS'(-dx) : COORD_BITS'(dx);
    assign ay = dy[COORD_BITS] ? COORD_BITS'(-dy) : COORD_BITS'(dy);
    assign too_short = (MD_W'(ax) < MD_W'(min_dist_reg))
                    && (MD_W'(ay) < MD_W'(min_dist_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_dist_reg  <= swd_pkg::MIN_DIST_W'(20);
            win_ticks_reg <= swd_pkg::WINDOW_W'(400);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                swd_pkg::REG_MIN_DISTANCE:
                    min_dist_reg  <= cfg_wdata[swd_pkg::MIN_DIST_W-1:0];
                swd_pkg::REG_WINDOW_TICKS:
                    win_ticks_reg <= cfg_wdata[swd_pkg::WINDOW_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        start_x_next   = start_x_reg;
        start_y_next   = start_y_reg;
        win_left_next  = win_left_reg;
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        angle_next     = angle_reg;
        cordic_start   = 1'b0;

        // drop the result once it is taken
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd)
                        swd_pkg::CMD_TICK:
                        begin
                            // count the window down, hold at zero
                            if (win_left_reg != '0)
                            begin
                                win_left_next = win_left_reg - 1'b1;
                            end
                            out_valid_next = 1'b1;
                            status_next    = swd_pkg::STAT_IGNORE;
                            angle_next     = '0;
                        end
                        swd_pkg::CMD_PRESS:
                        begin
                            start_x_next   = pos_x;
                            start_y_next   = pos_y;
                            win_left_next  = win_ticks_reg;
                            out_valid_next = 1'b1;
                            status_next    = swd_pkg::STAT_MAYBE;
                            angle_next     = '0;
                        end
                        swd_pkg::CMD_RELEASE:
                        begin
                            // the press point clears; the window keeps running
                            start_x_next = '0;
                            start_y_next = '0;
                            if (too_short || (win_left_reg == '0))
                            begin
                                out_valid_next = 1'b1;
                                status_next    = swd_pkg::STAT_CANCEL;
                                angle_next     = '0;
                            end
                            else
                            begin
                                cordic_start = 1'b1;
                                state_next   = ST_CALC;
                            end
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                            status_next    = swd_pkg::STAT_IGNORE;
                            angle_next     = '0;
                        end
                    endcase
                end
            end
            ST_CALC:
            begin
                // the slot was freed on acceptance, so load it straight away
                if (cstat.done)
                begin
                    out_valid_next = 1'b1;
                    status_next    = swd_pkg::STAT_FINISH;
                    angle_next     = cordic_angle;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            start_x_reg   <= '0;
            start_y_reg   <= '0;
            win_left_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            start_x_reg   <= start_x_next;
            start_y_reg   <= start_y_next;
            win_left_reg  <= win_left_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        angle_reg  <= angle_next;
    end

    swd_cordic #(
        .COORD_BITS       (COORD_BITS),
        .ANGLE_ITERATIONS (ANGLE_ITERATIONS)
    ) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cordic_start),
        .dx    (dx),
        .dy    (dy),
        .stat  (cstat),
        .angle (cordic_angle)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(24 - swd_pkg::STATUS_W - swd_pkg::ANGLE_W){1'b0}},
                       angle_reg, status_reg};

    // no item is taken while the angle is being worked out
    a_no_accept_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CALC) |-> !s_tready)
        else $error("input accepted during angle computation");

    // the angle unit is never busy while the sequencer is idle
    a_busy_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !cstat.busy)
        else $error("angle unit busy while sequencer idle");

    // a finished angle never lands on a result still waiting
    a_slot_free_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        cstat.done |-> ((state_reg == ST_CALC) && !out_valid_reg))
        else $error("angle done with result slot occupied");

    // angle is zero unless the result is a finish
    a_angle_only_on_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (status_reg != swd_pkg::STAT_FINISH)) |-> (angle_reg == '0))
        else $error("nonzero angle on a non-finish result");

endmodule
